>>> design/bmfa_pkg.sv
// Package of shared widths, status codes and sequencer states for the bitmap allocator.
package bmfa_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int IDX_W     = 16;
  localparam int CFG_W     = 17;
  localparam int STAT_W    = 2;

  // Map size after reset.
  localparam logic [CFG_W-1:0] MAP_BITS_RST = 17'd65536;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FRD,
    S_FWR,
    S_RESP
  } bmfa_state_e;

endpackage

>>> design/bmfa_if.sv
// Channel interfaces for requests, responses and the map size register write.
interface bmfa_req_if;
  import bmfa_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [IDX_W-1:0] unit_index;

  modport source (output valid, output mode, output unit_index, input ready);
  modport sink   (input valid, input mode, input unit_index, output ready);
endinterface

interface bmfa_rsp_if;
  import bmfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  granted_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, output granted_index, output status, input ready);
  modport sink   (input valid, input granted_index, input status, output ready);
endinterface

interface bmfa_cfg_if;
  import bmfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] map_bits;

  modport source (output valid, output map_bits, input ready);
  modport sink   (input valid, input map_bits, output ready);
endinterface

>>> design/bmfa_ffz.sv
// Find-first-free unit: lowest clear bit of a map word among the bits still inside the map.
module bmfa_ffz #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 17
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic [CNT_W-1:0]             span_i,
  output logic                         found_o,
  output logic [$clog2(WORD_BITS)-1:0] bit_o
);

  localparam int BW = $clog2(WORD_BITS);

  // Scan from the top so that the lowest free bit wins.
  always_comb begin
    found_o = 1'b0;
    bit_o   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word_i[b] && (CNT_W'(b) < span_i)) begin
        found_o = 1'b1;
        bit_o   = BW'(b);
      end
    end
  end

endmodule

>>> design/bitmap_first_fit_allocator_core.sv
// Top level of the first-fit bitmap allocator: sequencer, usage map memory and result register.
//
// Usage: requests arrive on req_i (mode 0 allocates the lowest free unit, mode 1 frees
// unit_index). Each request gives exactly one response on rsp_o with granted_index and
// status (done, no free unit, or free index out of range). cfg_i writes the map size and
// is always ready; write it only while no request is in flight.
// One request is worked on at a time; req_i is ready only while the sequencer is idle.
// An allocation reads the map one word per cycle through the single read port, with the
// check of each word overlapped with the read of the next.
// A free splits the index into word address and bit position by a shift and a mask
// (WORD_BITS is a power of two) and then does a read-modify-write of one word before
// its response. An out-of-range free goes straight to the response state.
// After reset a clearing pass writes zero to every map word, one word a cycle; requests
// are held off meanwhile.
// The response stays in its output register until taken. A finished request may start
// the next one while its response waits; that one holds its result until the register
// frees up.
module bitmap_first_fit_allocator_core
  import bmfa_pkg::*;
#(
  parameter int MAX_UNITS = 65536,
  parameter int WORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmfa_cfg_if.sink   cfg_i,
  bmfa_req_if.sink   req_i,
  bmfa_rsp_if.source rsp_o
);

  localparam int MAP_WORDS = (MAX_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int CW        = $clog2(MAX_UNITS + WORD_BITS + 1);
  localparam int GW        = (CW > CFG_W) ? CW : CFG_W;
  localparam int QW        = (AW > IDX_W) ? AW : IDX_W;

  bmfa_state_e state_q, state_d;

  logic [CFG_W-1:0]     map_bits_q;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;

  logic [CW-1:0]        limit_q, limit_d;
  logic [AW-1:0]        rd_w_q, rd_w_d;
  logic [CW-1:0]        rd_base_q, rd_base_d;
  logic [AW-1:0]        chk_w_q, chk_w_d;
  logic [CW-1:0]        chk_base_q, chk_base_d;
  logic [BW-1:0]        rem_q, rem_d;
  logic [IDX_W-1:0]     res_idx_q, res_idx_d;
  logic [STAT_W-1:0]    res_st_q, res_st_d;
  logic [IDX_W-1:0]     out_idx_q;
  logic [STAT_W-1:0]    out_st_q;
  logic                 load_out;

  // Usage map memory with registered read data.
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Combinational helpers.
  logic [GW-1:0]        limit_g;
  logic [CW-1:0]        limit_c;
  logic [CW-1:0]        span;
  logic                 ffz_found;
  logic [BW-1:0]        ffz_bit;
  logic [GW-1:0]        grant_g;
  logic [QW-1:0]        q_ext;
  logic [AW-1:0]        q_addr;
  logic                 idx_out_of_range;

  // Active map size saturates at the memory capacity.
  assign limit_g = (GW'(map_bits_q) > GW'(MAX_UNITS)) ? GW'(MAX_UNITS) : GW'(map_bits_q);
  assign limit_c = limit_g[CW-1:0];
  assign idx_out_of_range = GW'(req_i.unit_index) >= limit_g;

  // Units of the word under check that are still inside the map.
  assign span    = limit_q - chk_base_q;
  assign grant_g = GW'(chk_base_q) + GW'(ffz_bit);

  bmfa_ffz #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CW)
  ) u_ffz (
    .word_i  (rdata_q),
    .span_i  (span),
    .found_o (ffz_found),
    .bit_o   (ffz_bit)
  );

  // Word address of the unit named by a free request.
  assign q_ext  = QW'(req_i.unit_index >> BW);
  assign q_addr = q_ext[AW-1:0];

  // Configuration channel is always open.
  assign cfg_i.ready = 1'b1;

  // Response channel driven from the output register.
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_index = out_idx_q;
  assign rsp_o.status        = out_st_q;

  // Sequencer: next state, memory controls and datapath updates.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    limit_d     = limit_q;
    rd_w_d      = rd_w_q;
    rd_base_d   = rd_base_q;
    chk_w_d     = chk_w_q;
    chk_base_d  = chk_base_q;
    rem_d       = rem_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    mem_we      = 1'b0;
    mem_waddr   = chk_w_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = rd_w_q;
    req_i.ready = 1'b0;
    load_out    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          limit_d   = limit_c;
          res_idx_d = '0;
          if (!req_i.mode) begin
            rd_w_d    = '0;
            rd_base_d = '0;
            pend_d    = 1'b0;
            state_d   = S_SCAN;
          end else if (idx_out_of_range) begin
            res_st_d = STAT_RANGE;
            state_d  = S_RESP;
          end else begin
            chk_w_d = q_addr;
            rem_d   = req_i.unit_index[BW-1:0];
            state_d = S_FRD;
          end
        end
      end
      S_SCAN: begin
        // Check the word read last cycle while the next one is being read.
        if (pend_q && ffz_found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_w_q;
          mem_wdata = rdata_q | (WORD_BITS'(1) << ffz_bit);
          res_idx_d = grant_g[IDX_W-1:0];
          res_st_d  = STAT_DONE;
          pend_d    = 1'b0;
          state_d   = S_RESP;
        end else if (rd_base_q < limit_q) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_w_q;
          chk_w_d    = rd_w_q;
          chk_base_d = rd_base_q;
          rd_w_d     = rd_w_q + 1'b1;
          rd_base_d  = rd_base_q + CW'(WORD_BITS);
          pend_d     = 1'b1;
        end else begin
          pend_d   = 1'b0;
          res_st_d = STAT_FULL;
          state_d  = S_RESP;
        end
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = chk_w_q;
        state_d   = S_FWR;
      end
      S_FWR: begin
        mem_we    = 1'b1;
        mem_waddr = chk_w_q;
        mem_wdata = rdata_q & ~(WORD_BITS'(1) << rem_q);
        res_st_d  = STAT_DONE;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register empties when taken and fills when a result is loaded.
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      map_bits_q  <= MAP_BITS_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        map_bits_q <= cfg_i.map_bits;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    limit_q    <= limit_d;
    rd_w_q     <= rd_w_d;
    rd_base_q  <= rd_base_d;
    chk_w_q    <= chk_w_d;
    chk_base_q <= chk_base_d;
    rem_q      <= rem_d;
    res_idx_q  <= res_idx_d;
    res_st_q   <= res_st_d;
    if (load_out) begin
      out_idx_q <= res_idx_q;
      out_st_q  <= res_st_q;
    end
  end

  // Usage map memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

`ifndef SYNTH
  // A granted unit always lies inside the active map.
  a_grant_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q && ffz_found) |-> (grant_g < GW'(limit_q)))
    else $error("granted unit lies beyond the map size");

  // A word is only checked while its first unit is inside the map.
  a_check_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (chk_base_q < limit_q))
    else $error("scan checked a word beyond the map size");

  // An outstanding scan read never survives the scan state.
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("scan read pending outside the scan");

  // The unit being freed lies inside the active map.
  a_free_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRD || state_q == S_FWR) |-> (CW'({chk_w_q, rem_q}) < limit_q))
    else $error("freed unit lies beyond the map size");

  // No request is taken during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!req_i.ready && !load_out))
    else $error("request handled during the clearing pass");
`endif

endmodule
